// ===== rtl/ggpc_pkg.sv =====
// shared types, constants and helpers for the go-to-goal proportional controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ggpc_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int CORDIC_STAGES_MAX     = 30;

   // offset, cordic datapath and angle widths
   localparam int DW = 33;
   localparam int XW = 52;
   localparam int ZW = 33;
   localparam int EW = 18;

   localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314856;
   localparam logic signed [EW-1:0] PI_Q13      = 18'sd25736;
   localparam logic signed [EW-1:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic [19:0]          INVK_Q20    = 20'd636750;

   localparam logic [2:0] CSR_GOAL_X        = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y        = 3'd1;
   localparam logic [2:0] CSR_GOAL_HEADING  = 3'd2;
   localparam logic [2:0] CSR_GAIN_DISTANCE = 3'd3;
   localparam logic [2:0] CSR_GAIN_HEADING  = 3'd4;
   localparam logic [2:0] CSR_POS_TOL       = 3'd5;
   localparam logic [2:0] CSR_HEAD_TOL      = 3'd6;

   localparam logic [1:0] PHASE_DRIVE   = 2'd0;
   localparam logic [1:0] PHASE_TURN    = 2'd1;
   localparam logic [1:0] PHASE_REACHED = 2'd2;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [ZW-1:0] z;
      logic signed [15:0]   yaw;
      logic                 zero;
   } cordic_out_type;

   function automatic logic signed [ZW-1:0] atan_q29(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0:  r = 33'sd421657428;
         1:  r = 33'sd248918915;
         2:  r = 33'sd131521918;
         3:  r = 33'sd66762579;
         4:  r = 33'sd33510843;
         5:  r = 33'sd16771758;
         6:  r = 33'sd8387925;
         7:  r = 33'sd4194219;
         8:  r = 33'sd2097141;
         9:  r = 33'sd1048575;
         default: begin
            r = (i < CORDIC_STAGES_MAX) ? (33'sd1 <<< (29 - i)) : 33'sd0;
         end
      endcase
      return r;
   endfunction

   // single wrap into [-pi, pi]
   function automatic logic signed [EW-1:0] wrap_once(input logic signed [EW-1:0] e);
      logic signed [EW-1:0] r;
      if (e > PI_Q13) begin
         r = e - TWO_PI_Q13;
      end else if (e < -PI_Q13) begin
         r = e + TWO_PI_Q13;
      end else begin
         r = e;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/go_to_goal_p_controller_unit.sv =====
// go-to-goal proportional controller: goal registers, cordic pipeline, gain and phase stages
// depends on ggpc_pkg and ggpc_cordic
//
// usage:
//   req channel: one pose transaction (x, y, yaw) per cycle while req_ready is high, on req_valid / req_ready.
//   rsp channel: one velocity command (linear, angular, phase) per pose transaction.
//   csr channel: register writes by index, always ready; write only while idle.
// registers from req acceptance to rsp_valid, in order:
//   input register, one cordic iteration per stage, magnitude scaling,
//   distance and error wrap, gain products, output register.
// throughput: one transaction per cycle while rsp_ready is high, set by the fully
//   pipelined cordic and the split gain multipliers.
// stall: every stage holds its transaction while the next one is full and held;
//   empty stages keep filling, so req_ready stays high until the whole pipe is full.
// reset: synchronous; clears all valid bits and loads the register defaults
//   (goal at origin, unity gains, default tolerances).
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_p_controller_unit #(
   parameter int CORDIC_STAGES = ggpc_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pose_x,
   input  logic signed [31:0] req_pose_y,
   input  logic signed [15:0] req_pose_yaw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_linear_velocity,
   output logic signed [31:0] rsp_angular_velocity,
   output logic [1:0]         rsp_phase,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import ggpc_pkg::*;

   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic signed [15:0] goal_heading_ff;
   logic [15:0]        gain_distance_ff, gain_heading_ff;
   logic [30:0]        pos_tol_ff;
   logic [14:0]        head_tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff        <= '0;
         goal_y_ff        <= '0;
         goal_heading_ff  <= '0;
         gain_distance_ff <= 16'd256;
         gain_heading_ff  <= 16'd256;
         pos_tol_ff       <= 31'd6554;
         head_tol_ff      <= 15'd819;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GOAL_X:        goal_x_ff        <= csr_data;
            CSR_GOAL_Y:        goal_y_ff        <= csr_data;
            CSR_GOAL_HEADING:  goal_heading_ff  <= csr_data[15:0];
            CSR_GAIN_DISTANCE: gain_distance_ff <= csr_data[15:0];
            CSR_GAIN_HEADING:  gain_heading_ff  <= csr_data[15:0];
            CSR_POS_TOL:       pos_tol_ff       <= csr_data[30:0];
            CSR_HEAD_TOL:      head_tol_ff      <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // offsets to the goal
   logic signed [DW-1:0] dx, dy;
   assign dx = DW'(goal_x_ff) - DW'(req_pose_x);
   assign dy = DW'(goal_y_ff) - DW'(req_pose_y);

   logic           cor_valid, cor_ready;
   cordic_out_type cor_data;

   logic take_p1, take_p2, take_p3, take_rsp;

   ggpc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_dx     (dx),
      .in_dy     (dy),
      .in_yaw    (req_pose_yaw),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .out_data  (cor_data)
   );

   logic               p1_valid_ff, p2_valid_ff, p3_valid_ff, rsp_valid_ff;

   assign take_rsp  = !rsp_valid_ff || rsp_ready;
   assign take_p3   = !p3_valid_ff || take_rsp;
   assign take_p2   = !p2_valid_ff || take_p3;
   assign take_p1   = !p1_valid_ff || take_p2;
   assign cor_ready = take_p1;

   // stage 1: magnitude partial products, bearing rounding
   logic [40:0]        p1_pl_ff, p1_ph_ff, p1_pl_in, p1_ph_in;
   logic signed [16:0] p1_bear_ff, p1_bear_in;
   logic signed [15:0] p1_yaw_ff;
   logic               p1_zero_ff;
   logic [41:0]        mag;
   logic signed [ZW:0] zsum;

   always_comb begin
      mag        = cor_data.x[49:8];
      p1_pl_in   = 41'(mag[20:0]) * 41'(INVK_Q20);
      p1_ph_in   = 41'(mag[41:21]) * 41'(INVK_Q20);
      zsum       = (ZW+1)'(cor_data.z) + (ZW+1)'(32768);
      p1_bear_in = cor_data.zero ? 17'sd0 : zsum[32:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (take_p1) begin
         p1_valid_ff <= cor_valid;
      end
      if (take_p1) begin
         p1_pl_ff   <= p1_pl_in;
         p1_ph_ff   <= p1_ph_in;
         p1_bear_ff <= p1_bear_in;
         p1_yaw_ff  <= cor_data.yaw;
         p1_zero_ff <= cor_data.zero;
      end
   end

   // stage 2: distance, heading errors
   logic [34:0]          p2_dist_ff, p2_dist_in;
   logic signed [EW-1:0] p2_err0_ff, p2_fin_ff, p2_err0_in, p2_fin_in;
   logic [62:0]          dsum;

   always_comb begin
      dsum       = {p1_ph_ff, 21'd0} + 63'(p1_pl_ff) + 63'(1 << 27);
      p2_dist_in = p1_zero_ff ? 35'd0 : dsum[62:28];
      p2_err0_in = wrap_once(EW'(p1_bear_ff) - EW'(p1_yaw_ff));
      p2_fin_in  = wrap_once(EW'(goal_heading_ff) - EW'(p1_yaw_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (take_p2) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (take_p2) begin
         p2_dist_ff <= p2_dist_in;
         p2_err0_ff <= p2_err0_in;
         p2_fin_ff  <= p2_fin_in;
      end
   end

   // stage 3: phase decision, gain products
   logic [1:0]           p3_phase_ff, p3_phase_in;
   logic [33:0]          p3_lo_ff, p3_lo_in;
   logic [32:0]          p3_hi_ff, p3_hi_in;
   logic signed [34:0]   p3_ang_ff, p3_ang_in;
   logic signed [EW-1:0] fin_abs, err_sel;

   always_comb begin
      fin_abs = (p2_fin_ff < 0) ? -p2_fin_ff : p2_fin_ff;
      if (p2_dist_ff > 35'(pos_tol_ff)) begin
         p3_phase_in = PHASE_DRIVE;
      end else if (fin_abs > $signed(EW'(head_tol_ff))) begin
         p3_phase_in = PHASE_TURN;
      end else begin
         p3_phase_in = PHASE_REACHED;
      end
      err_sel   = (p3_phase_in == PHASE_DRIVE) ? p2_err0_ff : p2_fin_ff;
      p3_lo_in  = 34'(gain_distance_ff) * 34'(p2_dist_ff[17:0]);
      p3_hi_in  = 33'(gain_distance_ff) * 33'(p2_dist_ff[34:18]);
      p3_ang_in = $signed(35'(gain_heading_ff)) * 35'(err_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (take_p3) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (take_p3) begin
         p3_phase_ff <= p3_phase_in;
         p3_lo_ff    <= p3_lo_in;
         p3_hi_ff    <= p3_hi_in;
         p3_ang_ff   <= p3_ang_in;
      end
   end

   // output register: rounding, saturation, phase masking
   logic signed [31:0] rsp_lin_ff, rsp_ang_ff, lin_in, ang_in;
   logic [1:0]         rsp_phase_ff;
   logic [51:0]        lsum;
   logic [43:0]        lval;
   logic signed [35:0] asum;

   always_comb begin
      lsum = {1'b0, p3_hi_ff, 18'd0} + 52'(p3_lo_ff) + 52'd128;
      lval = lsum[51:8];
      asum = 36'(p3_ang_ff) + 36'sd16;
      if (p3_phase_ff != PHASE_DRIVE) begin
         lin_in = '0;
      end else if (|lval[43:31]) begin
         lin_in = 32'sh7fffffff;
      end else begin
         lin_in = $signed(lval[31:0]);
      end
      ang_in = (p3_phase_ff == PHASE_REACHED) ? 32'sd0 : 32'($signed(asum[35:5]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take_rsp) begin
         rsp_valid_ff <= p3_valid_ff;
      end
      if (take_rsp) begin
         rsp_lin_ff   <= lin_in;
         rsp_ang_ff   <= ang_in;
         rsp_phase_ff <= p3_phase_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_linear_velocity  = rsp_lin_ff;
   assign rsp_angular_velocity = rsp_ang_ff;
   assign rsp_phase            = rsp_phase_ff;

endmodule

`default_nettype wire

// ===== rtl/ggpc_cordic.sv =====
// pipelined vectoring cordic with pre-rotation, one iteration per register stage
// depends on ggpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ggpc_cordic #(
   parameter int STAGES = ggpc_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [ggpc_pkg::DW-1:0]      in_dx,
   input  logic signed [ggpc_pkg::DW-1:0]      in_dy,
   input  logic signed [15:0]                  in_yaw,
   output logic                                out_valid,
   input  logic                                out_ready,
   output ggpc_pkg::cordic_out_type            out_data
);
   import ggpc_pkg::*;

   logic signed [XW-1:0] x_ff   [0:STAGES];
   logic signed [XW-1:0] y_ff   [0:STAGES];
   logic signed [ZW-1:0] z_ff   [0:STAGES];
   logic signed [15:0]   yaw_ff [0:STAGES];
   logic                 zero_ff  [0:STAGES];
   logic                 valid_ff [0:STAGES];
   logic                 take [0:STAGES];

   logic signed [XW-1:0] x0, y0, x_in, y_in;
   logic signed [ZW-1:0] z_in;

   always_comb begin
      take[STAGES] = !valid_ff[STAGES] || out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
   end

   assign in_ready = take[0];

   // pre-rotation into the right half plane
   always_comb begin
      x0 = XW'(in_dx) <<< 16;
      y0 = XW'(in_dy) <<< 16;
      x_in = x0;
      y_in = y0;
      z_in = '0;
      if (in_dx < 0) begin
         if (in_dy >= 0) begin
            x_in = y0;
            y_in = -x0;
            z_in = HALF_PI_Q29;
         end else begin
            x_in = -y0;
            y_in = x0;
            z_in = -HALF_PI_Q29;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (take[0]) begin
         valid_ff[0] <= in_valid;
      end
      if (take[0]) begin
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         yaw_ff[0]  <= in_yaw;
         zero_ff[0] <= (in_dx == '0) && (in_dy == '0);
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_iter
      localparam logic signed [ZW-1:0] ANG = atan_q29(k);
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (take[k+1]) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (take[k+1]) begin
            if (y_ff[k] > 0) begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + ANG;
            end else begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - ANG;
            end
            yaw_ff[k+1]  <= yaw_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   assign out_valid     = valid_ff[STAGES];
   assign out_data.x    = x_ff[STAGES];
   assign out_data.z    = z_ff[STAGES];
   assign out_data.yaw  = yaw_ff[STAGES];
   assign out_data.zero = zero_ff[STAGES];

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for go_to_goal_p_controller_unit: directed poses, then random poses
// under several goal/gain/tolerance settings; each command checked against its row or a built-in predictor
// depends on ggpc_pkg and go_to_goal_p_controller_unit
`timescale 1ns / 1ps

module tb_top;
   import ggpc_pkg::*;

   localparam int         STAGES      = CORDIC_STAGES_DEFAULT;
   localparam int         DRAIN       = STAGES + 12;
   localparam int         CYCLE_LIMIT = 400000;
   localparam logic [2:0] CSR_SPARE   = 3'd7;

   typedef struct packed {
      logic signed [31:0] linear;
      logic signed [31:0] angular;
      logic [1:0]         phase;
   } vel_cmd_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] yaw;
      bit                 typed;
      vel_cmd_type        cmd;
   } pose_row_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_pose_x = 0;
   logic signed [31:0] req_pose_y = 0;
   logic signed [15:0] req_pose_yaw = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_linear_velocity;
   logic signed [31:0] rsp_angular_velocity;
   logic [1:0]         rsp_phase;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_index = 0;
   logic [31:0]        csr_data = 0;

   // controller settings as the predictor sees them
   logic signed [31:0] goal_x, goal_y;
   logic signed [15:0] goal_heading;
   logic [15:0]        gain_distance, gain_heading;
   logic [30:0]        pos_tol;
   logic [14:0]        head_tol;

   vel_cmd_type cmd_queue[$];
   int       mismatches = 0;
   int       cycles = 0;
   bit       quiet = 0;
   bit       hold_req = 0;
   pose_row_type rows[$];

   longint atan_tab[30] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
      8, 4, 2, 1};

   go_to_goal_p_controller_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[go_to_goal_p_controller_unit] ERROR");
         $finish;
      end
   end

   function automatic longint half_turn(input longint e);
      if (e > 25736) return e - 51472;
      if (e < -25736) return e + 51472;
      return e;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic vel_cmd_type steer(input logic signed [31:0] px,
                                         input logic signed [31:0] py,
                                         input logic signed [15:0] yaw);
      longint dx, dy, x, y, z, t, xs, ys, range, bearing, fin, lin, ang;
      vel_cmd_type c;
      dx = longint'(goal_x) - longint'(px);
      dy = longint'(goal_y) - longint'(py);
      range = 0;
      bearing = 0;
      if (dx != 0 || dy != 0) begin
         x = dx * 65536;
         y = dy * 65536;
         z = 0;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y; y = -t; z = 843314856;
            end else begin
               x = -y; y = t; z = -843314856;
            end
         end
         for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys; y -= xs; z += atan_tab[i];
            end else begin
               x -= ys; y += xs; z -= atan_tab[i];
            end
         end
         range = ((x >>> 8) * 636750 + (64'sd1 <<< 27)) >>> 28;
         bearing = (z + 32768) >>> 16;
      end
      fin = half_turn(longint'(goal_heading) - longint'(yaw));
      lin = 0;
      ang = 0;
      if (range > longint'(pos_tol)) begin
         c.phase = PHASE_DRIVE;
         lin = (longint'(gain_distance) * range + 128) >>> 8;
         ang = (longint'(gain_heading) * half_turn(bearing - longint'(yaw)) + 16) >>> 5;
      end else if ((fin < 0 ? -fin : fin) > longint'(head_tol)) begin
         c.phase = PHASE_TURN;
         ang = (longint'(gain_heading) * fin + 16) >>> 5;
      end else begin
         c.phase = PHASE_REACHED;
      end
      c.linear = clamp32(lin);
      c.angular = clamp32(ang);
      return c;
   endfunction

   // response side check
   always @(posedge clock) begin
      vel_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cmd_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected command transaction");
         end else begin
            want = cmd_queue.pop_front();
            if (want.linear !== rsp_linear_velocity || want.angular !== rsp_angular_velocity ||
                want.phase !== rsp_phase) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp lin %0d ang %0d phase %0d, got lin %0d ang %0d phase %0d",
                           want.linear, want.angular, want.phase, rsp_linear_velocity,
                           rsp_angular_velocity, rsp_phase);
            end
         end
      end
   end

   // receiver: random stalls, a quiet stretch and one long hold-off
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            held = 1;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (quiet) begin
            rsp_ready <= 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 34);
         end
      end
   end

   task automatic send_pose(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [15:0] yaw, input bit typed,
                            input vel_cmd_type cmd);
      if (!quiet && $urandom_range(99) < 34) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1;
      req_pose_x <= px;
      req_pose_y <= py;
      req_pose_yaw <= yaw;
      do @(posedge clock); while (!req_ready);
      cmd_queue.push_back(typed ? cmd : steer(px, py, yaw));
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GOAL_X:        goal_x = data;
         CSR_GOAL_Y:        goal_y = data;
         CSR_GOAL_HEADING:  goal_heading = data[15:0];
         CSR_GAIN_DISTANCE: gain_distance = data[15:0];
         CSR_GAIN_HEADING:  gain_heading = data[15:0];
         CSR_POS_TOL:       pos_tol = data[30:0];
         CSR_HEAD_TOL:      head_tol = data[14:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (cmd_queue.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] gx, input logic [31:0] gy, input logic [15:0] gh,
                            input logic [15:0] kd, input logic [15:0] kh,
                            input logic [30:0] ptol, input logic [14:0] htol);
      drain();
      write_csr(CSR_GOAL_X, gx);
      write_csr(CSR_GOAL_Y, gy);
      write_csr(CSR_GOAL_HEADING, {16'h0, gh});
      write_csr(CSR_GAIN_DISTANCE, {16'h0, kd});
      write_csr(CSR_GAIN_HEADING, {16'h0, kh});
      write_csr(CSR_POS_TOL, {1'b0, ptol});
      write_csr(CSR_HEAD_TOL, {17'h0, htol});
      write_csr(CSR_SPARE, $urandom);
      csr_valid <= 0;
   endtask

   task automatic random_poses(input int count);
      logic signed [31:0] px, py;
      logic signed [15:0] yaw;
      vel_cmd_type none;
      none = '0;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(3))
            0: begin
               px = $urandom;
               py = $urandom;
            end
            1: begin
               px = goal_x + $signed(32'($urandom_range(0, 16000)) - 32'sd8000);
               py = goal_y + $signed(32'($urandom_range(0, 16000)) - 32'sd8000);
            end
            default: begin
               px = goal_x + $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
               py = goal_y + $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
            end
         endcase
         yaw = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 51472)) - 25736);
         send_pose(px, py, yaw, 0, none);
      end
   endtask

   function automatic void add_row(input logic signed [31:0] x, input logic signed [31:0] y,
                                   input logic signed [15:0] yaw, input bit typed,
                                   input logic signed [31:0] lin, input logic signed [31:0] ang,
                                   input logic [1:0] ph);
      pose_row_type r;
      r.x = x; r.y = y; r.yaw = yaw; r.typed = typed;
      r.cmd.linear = lin; r.cmd.angular = ang; r.cmd.phase = ph;
      rows.push_back(r);
   endfunction

   initial begin
      goal_x = 0; goal_y = 0; goal_heading = 0;
      gain_distance = 256; gain_heading = 256;
      pos_tol = 6554; head_tol = 819;

      // directed stimulus, default settings
      add_row(0, 0, 0, 1, 0, 0, PHASE_REACHED);
      add_row(0, 0, 16'sd10000, 1, 0, -32'sd80000, PHASE_TURN);
      add_row(0, 0, -16'sd25736, 1, 0, 32'sd205888, PHASE_TURN);
      add_row(0, 0, 16'sd32767, 1, 0, 32'sd149640, PHASE_TURN);
      add_row(0, 0, -16'sd32768, 0, 0, 0, 0);
      add_row(0, 0, 16'sd819, 1, 0, 0, PHASE_REACHED);
      add_row(6554, 0, 0, 0, 0, 0, 0);
      add_row(6555, 0, 0, 0, 0, 0, 0);
      add_row(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0, 0);
      add_row(32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 0);
      add_row(32'sh80000000, 32'sh7fffffff, 16'sd25736, 0, 0, 0, 0);
      add_row(32'sh7fffffff, 32'sh80000000, -16'sd25736, 0, 0, 0, 0);
      add_row(-32'sd65536, 0, 0, 0, 0, 0, 0);
      add_row(0, -32'sd65536, 0, 0, 0, 0, 0);
      add_row(-32'sd65536, 32'sd65536, 0, 0, 0, 0, 0);
      add_row(-32'sd65536, -32'sd65536, 0, 0, 0, 0, 0);
      add_row(32'sd65536, 0, 16'sd32767, 0, 0, 0, 0);
      add_row(32'hffffffff, 32'hffffffff, 16'hffff, 0, 0, 0, 0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (rows[i]) send_pose(rows[i].x, rows[i].y, rows[i].yaw, rows[i].typed, rows[i].cmd);

      quiet = 1;
      random_poses(60);
      quiet = 0;
      hold_req = 1;
      random_poses(60);

      configure(32'h7fffffff, 32'h80000000, 16'sd25736, 16'hffff, 16'hffff, 31'h7fffffff, 15'h7fff);
      random_poses(60);
      configure(32'h80000000, 32'h7fffffff, -16'sd25736, 16'h0, 16'h0, 31'h0, 15'h0);
      random_poses(60);
      configure($urandom, $urandom, 16'($signed($urandom_range(0, 51472)) - 25736),
                16'($urandom), 16'($urandom), 31'($urandom_range(0, 400000)),
                15'($urandom_range(0, 4000)));
      random_poses(70);
      configure(32'h00012345, 32'hfffe0000, 16'sd1234, 16'd512, 16'd128, 31'd1000000, 15'd2000);
      random_poses(70);
      configure(32'sd0, 32'sd0, 16'sd32767, 16'd256, 16'd300, 31'd6554, 15'd819);
      random_poses(50);

      drain();
      if (mismatches == 0) begin
         $display("[go_to_goal_p_controller_unit] OK");
      end else begin
         $display("[go_to_goal_p_controller_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ggpc_pkg.sv
rtl/ggpc_cordic.sv
rtl/go_to_goal_p_controller_unit.sv
tb/sv/tb_top.sv
